// ===== design/dda_pkg.sv =====
// Shared types, widths and codes for the DDA line rasterizer.
package dda_pkg;

    localparam int COORD_BITS   = 9;
    localparam int FRAC_BITS    = 16;
    localparam int ACC_BITS     = COORD_BITS + FRAC_BITS;
    localparam int STEP_BITS    = FRAC_BITS + 2;
    localparam int CNT_BITS     = COORD_BITS + 1;
    localparam int QUO_BITS     = FRAC_BITS + 1;
    localparam int DIV_CNT_BITS = $clog2(FRAC_BITS + 1);

    localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(FRAC_BITS);
    localparam logic [ACC_BITS-1:0]     ACC_HALF = ACC_BITS'(1) << (FRAC_BITS - 1);

    // Request opcodes
    typedef enum logic
    {
        FUNC_LOAD    = 1'b0,
        FUNC_ADVANCE = 1'b1
    } func_t;

    typedef struct packed
    {
        func_t                 func;
        logic [COORD_BITS-1:0] x_start;
        logic [COORD_BITS-1:0] y_start;
        logic [COORD_BITS-1:0] x_end;
        logic [COORD_BITS-1:0] y_end;
    } cmd_t;

    typedef struct packed
    {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic                  last_pixel;
    } pix_t;

    // Sequencer to divider
    typedef struct packed
    {
        logic                  start;
        logic [COORD_BITS-1:0] dividend;
        logic [COORD_BITS-1:0] divisor;
    } div_req_t;

    // Divider to sequencer
    typedef struct packed
    {
        logic                done;
        logic [QUO_BITS-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== design/dda_cmd_if.sv =====
// Request channel carrying load and advance commands.
interface dda_cmd_if;
    logic          valid;
    logic          ready;
    dda_pkg::cmd_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/dda_pix_if.sv =====
// Result channel carrying emitted pixels.
interface dda_pix_if;
    logic          valid;
    logic          ready;
    dda_pkg::pix_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/dda_line_rasterizer_unit.sv =====
// DDA line rasterizer top level: command sequencer, accumulators, output register.
// A load request keeps the unit busy while one shared serial divider works out
// the x and the y increment in turn, one quotient bit per cycle, and then the
// unit is ready again; a zero-length line does not make it busy at all.
// An advance request emits one pixel into the output register; a new request
// is taken whenever that register is empty or being drained, so pixels stream
// at one per clock. Loads emit nothing, and advances with no active line are
// absorbed silently.
module dda_line_rasterizer_unit
(
    input  logic   clk,
    input  logic   rst_n,
    dda_cmd_if.sink   cmd,
    dda_pix_if.source pix
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Y
    } state_t;

    state_t                           state_reg, state_next;
    logic [dda_pkg::ACC_BITS-1:0]     accum_x_reg, accum_x_next;
    logic [dda_pkg::ACC_BITS-1:0]     accum_y_reg, accum_y_next;
    logic [dda_pkg::STEP_BITS-1:0]    step_x_reg, step_x_next;
    logic [dda_pkg::STEP_BITS-1:0]    step_y_reg, step_y_next;
    logic [dda_pkg::CNT_BITS-1:0]     steps_left_reg, steps_left_next;
    logic                             active_reg, active_next;
    logic                             neg_x_reg, neg_x_next;
    logic                             neg_y_reg, neg_y_next;
    logic [dda_pkg::COORD_BITS-1:0]   mag_y_reg, mag_y_next;
    logic [dda_pkg::COORD_BITS-1:0]   len_reg, len_next;
    logic                             out_valid_reg, out_valid_next;
    dda_pkg::pix_t                    out_reg, out_next;

    logic                             accept;
    logic                             neg_x, neg_y;
    logic [dda_pkg::COORD_BITS-1:0]   mag_x, mag_y, len;
    logic [dda_pkg::STEP_BITS-1:0]    quo_ext, quo_neg;
    dda_pkg::div_req_t                div_req;
    dda_pkg::div_rsp_t                div_rsp;

    dda_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Handshake
    assign cmd.ready   = (state_reg == ST_IDLE) && (!out_valid_reg || pix.ready);
    assign accept      = cmd.valid && cmd.ready;
    assign pix.valid   = out_valid_reg;
    assign pix.payload = out_reg;

    // Endpoint differences and step count
    assign neg_x = cmd.payload.x_end < cmd.payload.x_start;
    assign neg_y = cmd.payload.y_end < cmd.payload.y_start;
    assign mag_x = neg_x ? (cmd.payload.x_start - cmd.payload.x_end)
                         : (cmd.payload.x_end - cmd.payload.x_start);
    assign mag_y = neg_y ? (cmd.payload.y_start - cmd.payload.y_end)
                         : (cmd.payload.y_end - cmd.payload.y_start);
    assign len   = (mag_x >= mag_y) ? mag_x : mag_y;

    // Quotient magnitude to signed increment
    assign quo_ext = {1'b0, div_rsp.quotient};
    assign quo_neg = -quo_ext;

    always_comb
    begin
        state_next      = state_reg;
        accum_x_next    = accum_x_reg;
        accum_y_next    = accum_y_reg;
        step_x_next     = step_x_reg;
        step_y_next     = step_y_reg;
        steps_left_next = steps_left_reg;
        active_next     = active_reg;
        neg_x_next      = neg_x_reg;
        neg_y_next      = neg_y_reg;
        mag_y_next      = mag_y_reg;
        len_next        = len_reg;
        out_valid_next  = out_valid_reg && !pix.ready;
        out_next        = out_reg;
        div_req.start    = 1'b0;
        div_req.dividend = mag_x;
        div_req.divisor  = len;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd.payload.func == dda_pkg::FUNC_LOAD))
                begin
                    if (len == '0)
                    begin
                        active_next     = 1'b0;
                        steps_left_next = '0;
                    end
                    else
                    begin
                        // Start accumulators at the start point plus one half
                        accum_x_next = {cmd.payload.x_start, {dda_pkg::FRAC_BITS{1'b0}}}
                                       | dda_pkg::ACC_HALF;
                        accum_y_next = {cmd.payload.y_start, {dda_pkg::FRAC_BITS{1'b0}}}
                                       | dda_pkg::ACC_HALF;
                        steps_left_next = {1'b0, len};
                        active_next     = 1'b0;
                        neg_x_next      = neg_x;
                        neg_y_next      = neg_y;
                        mag_y_next      = mag_y;
                        len_next        = len;
                        div_req.start   = 1'b1;
                        state_next      = ST_DIV_X;
                    end
                end
                else if (accept && active_reg)
                begin
                    // Emit current pixel, then step
                    out_valid_next     = 1'b1;
                    out_next.pixel_x   = accum_x_reg[dda_pkg::ACC_BITS-1:dda_pkg::FRAC_BITS];
                    out_next.pixel_y   = accum_y_reg[dda_pkg::ACC_BITS-1:dda_pkg::FRAC_BITS];
                    out_next.last_pixel = (steps_left_reg == dda_pkg::CNT_BITS'(1));
                    accum_x_next = accum_x_reg + {{(dda_pkg::ACC_BITS - dda_pkg::STEP_BITS)
                                   {step_x_reg[dda_pkg::STEP_BITS-1]}}, step_x_reg};
                    accum_y_next = accum_y_reg + {{(dda_pkg::ACC_BITS - dda_pkg::STEP_BITS)
                                   {step_y_reg[dda_pkg::STEP_BITS-1]}}, step_y_reg};
                    steps_left_next = steps_left_reg - 1'b1;
                    if (steps_left_reg == dda_pkg::CNT_BITS'(1))
                    begin
                        active_next = 1'b0;
                    end
                end
            end
            ST_DIV_X:
            begin
                if (div_rsp.done)
                begin
                    step_x_next      = neg_x_reg ? quo_neg : quo_ext;
                    div_req.start    = 1'b1;
                    div_req.dividend = mag_y_reg;
                    div_req.divisor  = len_reg;
                    state_next       = ST_DIV_Y;
                end
            end
            ST_DIV_Y:
            begin
                if (div_rsp.done)
                begin
                    step_y_next = neg_y_reg ? quo_neg : quo_ext;
                    active_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            accum_x_reg    <= '0;
            accum_y_reg    <= '0;
            step_x_reg     <= '0;
            step_y_reg     <= '0;
            steps_left_reg <= '0;
            active_reg     <= 1'b0;
            neg_x_reg      <= 1'b0;
            neg_y_reg      <= 1'b0;
            mag_y_reg      <= '0;
            len_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            accum_x_reg    <= accum_x_next;
            accum_y_reg    <= accum_y_next;
            step_x_reg     <= step_x_next;
            step_y_reg     <= step_y_next;
            steps_left_reg <= steps_left_next;
            active_reg     <= active_next;
            neg_x_reg      <= neg_x_next;
            neg_y_reg      <= neg_y_next;
            mag_y_reg      <= mag_y_next;
            len_reg        <= len_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
        end
    end

    // No request is taken while the divider works
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !cmd.ready)
        else $error("request taken during increment division");

    // Divider completes only while the sequencer waits for it
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV_X || state_reg == ST_DIV_Y))
        else $error("divider completion outside a division phase");

    // An active line always has pixels left
    a_active_count: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (steps_left_reg != '0))
        else $error("active line with no steps left");

    // An advance on an active line yields a pixel next cycle
    a_advance_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.payload.func == dda_pkg::FUNC_ADVANCE && active_reg)
        |=> pix.valid)
        else $error("advance on active line produced no pixel");

endmodule

// ===== design/dda_div.sv =====
// Radix-2 restoring divider: (dividend << FRAC_BITS) / divisor, dividend <= divisor.
module dda_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  dda_pkg::div_req_t req,
    output dda_pkg::div_rsp_t rsp
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [dda_pkg::DIV_CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [dda_pkg::CNT_BITS-1:0]      rem_reg, rem_next;
    logic [dda_pkg::QUO_BITS-1:0]      quo_reg, quo_next;
    logic [dda_pkg::COORD_BITS-1:0]    den_reg, den_next;
    logic [dda_pkg::CNT_BITS-1:0]      diff;
    logic                              ge;
    logic [dda_pkg::CNT_BITS-1:0]      rem_sel;

    // One quotient bit per cycle: compare, subtract, shift
    assign ge      = rem_reg >= {1'b0, den_reg};
    assign diff    = rem_reg - {1'b0, den_reg};
    assign rem_sel = ge ? diff : rem_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = {1'b0, req.dividend};
            quo_next  = '0;
            den_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[dda_pkg::QUO_BITS-2:0], ge};
            rem_next = {rem_sel[dda_pkg::CNT_BITS-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == dda_pkg::DIV_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            den_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            den_reg  <= den_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the DDA line rasterizer: directed and random line traffic.
`timescale 1ns / 1ps

module tb_top;

    localparam int COORD_MAX   = (1 << dda_pkg::COORD_BITS) - 1;
    localparam int HOLD_CYCLES = 400;
    localparam int END_CYCLES  = 2 * (dda_pkg::FRAC_BITS + 1) + 8;
    localparam int STALL_LIMIT = 4000;
    localparam int PRINT_CAP   = 40;

    logic clk;
    logic rst_n = 1'b0;

    dda_cmd_if cmd_ch ();
    dda_pix_if pix_ch ();

    dda_line_rasterizer_unit u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch.sink),
        .pix   (pix_ch.source)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Line state as the block should hold it
    logic [dda_pkg::ACC_BITS-1:0]         ln_acc_x;
    logic [dda_pkg::ACC_BITS-1:0]         ln_acc_y;
    logic signed [dda_pkg::STEP_BITS-1:0] ln_step_x;
    logic signed [dda_pkg::STEP_BITS-1:0] ln_step_y;
    logic [dda_pkg::CNT_BITS-1:0]         ln_left;
    logic                                 ln_active;

    dda_pkg::pix_t pixel_queue[$];
    int   mismatch_cnt  = 0;
    int   live_items    = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_trig     = 0;
    int   hold_seen     = 0;
    int   stall_cnt     = 0;

    // Signed per-step increment d/span, fraction bits, truncated toward zero
    function automatic logic signed [dda_pkg::STEP_BITS-1:0] line_incr(input int d,
                                                                       input int span);
        int q;
        q = ((d < 0 ? -d : d) << dda_pkg::FRAC_BITS) / span;
        return (d < 0) ? dda_pkg::STEP_BITS'(-q) : dda_pkg::STEP_BITS'(q);
    endfunction

    function automatic logic [dda_pkg::ACC_BITS-1:0] widen_step(
        input logic signed [dda_pkg::STEP_BITS-1:0] s);
        return {{(dda_pkg::ACC_BITS - dda_pkg::STEP_BITS){s[dda_pkg::STEP_BITS-1]}}, s};
    endfunction

    // Apply one request to the line state; returns 1 when a pixel comes out
    function automatic bit rasterize_step(input dda_pkg::cmd_t req, output dda_pkg::pix_t px);
        int dx;
        int dy;
        int span;
        px = '0;
        if (req.func == dda_pkg::FUNC_LOAD)
        begin
            dx   = int'(req.x_end) - int'(req.x_start);
            dy   = int'(req.y_end) - int'(req.y_start);
            span = (dx < 0) ? -dx : dx;
            if (((dy < 0) ? -dy : dy) > span)
                span = (dy < 0) ? -dy : dy;
            if (span == 0)
            begin
                ln_active = 1'b0;
                ln_left   = '0;
            end
            else
            begin
                ln_step_x = line_incr(dx, span);
                ln_step_y = line_incr(dy, span);
                ln_acc_x  = (dda_pkg::ACC_BITS'(req.x_start) << dda_pkg::FRAC_BITS)
                            | dda_pkg::ACC_HALF;
                ln_acc_y  = (dda_pkg::ACC_BITS'(req.y_start) << dda_pkg::FRAC_BITS)
                            | dda_pkg::ACC_HALF;
                ln_left   = dda_pkg::CNT_BITS'(span);
                ln_active = 1'b1;
            end
            return 1'b0;
        end
        // advance with nothing loaded is absorbed
        if (!ln_active)
            return 1'b0;
        px.pixel_x    = ln_acc_x[dda_pkg::ACC_BITS-1:dda_pkg::FRAC_BITS];
        px.pixel_y    = ln_acc_y[dda_pkg::ACC_BITS-1:dda_pkg::FRAC_BITS];
        px.last_pixel = (ln_left == dda_pkg::CNT_BITS'(1));
        ln_acc_x      = ln_acc_x + widen_step(ln_step_x);
        ln_acc_y      = ln_acc_y + widen_step(ln_step_y);
        ln_left       = ln_left - dda_pkg::CNT_BITS'(1);
        if (ln_left == '0)
            ln_active = 1'b0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_cnt < PRINT_CAP)
            $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_cnt++;
    endtask

    // Send one request, wait for the handshake, then predict its pixel
    task automatic send_req(input dda_pkg::cmd_t req);
        dda_pkg::pix_t px;
        bit            emitted;
        // idle cycles before the request
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.payload <= req;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        emitted = rasterize_step(req, px);
        if (emitted)
            pixel_queue.push_back(px);
        if (emitted || req.func == dda_pkg::FUNC_LOAD)
            live_items++;
    endtask

    task automatic load_line(input int xs, input int ys, input int xe, input int ye);
        dda_pkg::cmd_t req;
        req.func    = dda_pkg::FUNC_LOAD;
        req.x_start = dda_pkg::COORD_BITS'(xs);
        req.y_start = dda_pkg::COORD_BITS'(ys);
        req.x_end   = dda_pkg::COORD_BITS'(xe);
        req.y_end   = dda_pkg::COORD_BITS'(ye);
        send_req(req);
    endtask

    // Advances carry random coordinates, which the block must ignore
    task automatic advance(input int count);
        dda_pkg::cmd_t req;
        repeat (count)
        begin
            req         = dda_pkg::cmd_t'($urandom);
            req.func    = dda_pkg::FUNC_ADVANCE;
            req.x_start = dda_pkg::COORD_BITS'($urandom);
            req.y_start = dda_pkg::COORD_BITS'($urandom);
            req.x_end   = dda_pkg::COORD_BITS'($urandom);
            req.y_end   = dda_pkg::COORD_BITS'($urandom);
            send_req(req);
        end
    endtask

    // Sender stops and waits for every outstanding pixel
    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pixel_queue.size() != 0);
    endtask

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    function automatic int clamp_coord(input int v);
        return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    // Advance right after reset, nothing loaded
    task automatic test_idle_advance();
        advance(1);
    endtask

    // Corner to corner lines, each replaced by the next one mid-way
    task automatic test_extreme_endpoints();
        load_line(0, 0, COORD_MAX, COORD_MAX);
        advance(3);
        load_line(COORD_MAX, COORD_MAX, 0, 0);
        advance(3);
        load_line(COORD_MAX, 0, 0, COORD_MAX);
        advance(2);
    endtask

    // Identical endpoints: nothing drawn after the load
    task automatic test_zero_length();
        load_line(7, 7, 7, 7);
        advance(2);
    endtask

    // Full short lines: last pixel flag, end point skipped, advance past the end
    task automatic test_short_lines();
        load_line(10, 20, 13, 18);
        advance(4);
        load_line(100, 100, 98, 95);
        advance(5);
    endtask

    // Receiver holds off while the sender keeps pushing advances
    task automatic test_output_stall();
        wait_drained();
        hold_trig++;
        load_line(0, 0, COORD_MAX, 100);
        advance(80);
        wait_drained();
    endtask

    // Mostly whole lines with random endpoints, some cut short or overrun, some noise
    task automatic test_random_lines(input int target);
        int            first;
        int            pick;
        int            span;
        int            len;
        int            nadv;
        int            xs;
        int            ys;
        int            xe;
        int            ye;
        dda_pkg::cmd_t req;
        first = live_items;
        while (live_items - first < target)
        begin
            pick = $urandom_range(99);
            if (pick < 6)
            begin
                // noise: any request with any fields
                req = dda_pkg::cmd_t'({$urandom, $urandom});
                send_req(req);
            end
            else
            begin
                xs   = $urandom_range(COORD_MAX);
                ys   = $urandom_range(COORD_MAX);
                pick = $urandom_range(99);
                if (pick < 3)
                begin
                    xe = xs;
                    ye = ys;
                end
                else if (pick < 8)
                begin
                    xe = $urandom_range(COORD_MAX);
                    ye = $urandom_range(COORD_MAX);
                end
                else
                begin
                    span = (pick < 85) ? 24 : 128;
                    xe   = clamp_coord(xs + int'($urandom_range(2 * span)) - span);
                    ye   = clamp_coord(ys + int'($urandom_range(2 * span)) - span);
                end
                len = (xe > xs) ? xe - xs : xs - xe;
                if (((ye > ys) ? ye - ys : ys - ye) > len)
                    len = (ye > ys) ? ye - ys : ys - ye;
                pick = $urandom_range(99);
                nadv = len;
                if (pick < 12)
                    nadv = $urandom_range(len);
                else if (pick < 22)
                    nadv = len + $urandom_range(1, 3);
                load_line(xs, ys, xe, ye);
                advance(nadv);
            end
        end
    endtask

    // Receiver: random ready, with a long hold-off on request
    initial
    begin
        pix_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_trig != hold_seen)
            begin
                hold_seen = hold_trig;
                pix_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            pix_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Pixel checker
    always @(posedge clk)
    begin
        dda_pkg::pix_t want;
        dda_pkg::pix_t got;
        if (rst_n && pix_ch.valid && pix_ch.ready)
        begin
            got = pix_ch.payload;
            if (pixel_queue.size() == 0)
                report_mismatch("unexpected pixel, x", got.pixel_x, -1);
            else
            begin
                want = pixel_queue.pop_front();
                if (got.pixel_x !== want.pixel_x)
                    report_mismatch("pixel_x", got.pixel_x, want.pixel_x);
                if (got.pixel_y !== want.pixel_y)
                    report_mismatch("pixel_y", got.pixel_y, want.pixel_y);
                if (got.last_pixel !== want.last_pixel)
                    report_mismatch("last_pixel", got.last_pixel, want.last_pixel);
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_ch.valid && cmd_ch.ready) || (pix_ch.valid && pix_ch.ready))
                stall_cnt <= 0;
            else if (stall_cnt >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
                stall_cnt <= stall_cnt + 1;
        end
    end

    // Test sequence
    initial
    begin
        cmd_ch.valid   = 1'b0;
        cmd_ch.payload = '0;
        ln_acc_x       = '0;
        ln_acc_y       = '0;
        ln_step_x      = '0;
        ln_step_y      = '0;
        ln_left        = '0;
        ln_active      = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idle(37, 76);
        test_idle_advance();
        test_extreme_endpoints();
        test_zero_length();
        test_short_lines();
        test_random_lines(420);

        set_idle(76, 37);
        test_random_lines(420);

        set_idle(0, 0);
        test_output_stall();
        test_random_lines(420);

        wait_drained();
        repeat (END_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0 && pixel_queue.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
design/dda_pkg.sv
design/dda_cmd_if.sv
design/dda_pix_if.sv
design/dda_div.sv
design/dda_line_rasterizer_unit.sv
tb/tb_top.sv
